// ===== rtl/core/sgvc_pkg.sv =====
// Shared types, constants and math helpers for the sigmoid-gain velocity controller.
package sgvc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ROM_DEPTH = 256;
    localparam int ROM_AW    = 8;
    localparam int ROM_W     = 17;
    localparam int ARG_LIMIT = 8;
    localparam int ARG_SHIFT = 4;                      // log2(2*ARG_LIMIT)
    localparam int ARG_LIM_Q = ARG_LIMIT << FRAC_BITS;
    localparam int ARG_W     = 21;                     // clamped argument plus limit
    localparam int POS_W     = 29;                     // ARG_W + ROM_AW
    localparam int U_W       = 50;
    localparam int PROD_W    = 66;
    localparam int EXP_BITS  = 24;
    localparam int EXP_TERMS = 48;
    localparam int GAIN_LAT  = 11;
    localparam int SQRT_LAT  = 32;

    localparam logic [31:0] CFG_RESET = 32'd65536;

    typedef enum logic [2:0] {
        REG_NEAR_GAIN     = 3'd0,
        REG_FAR_GAIN      = 3'd1,
        REG_NEAR_SLOPE    = 3'd2,
        REG_FAR_SLOPE     = 3'd3,
        REG_NEAR_DISTANCE = 3'd4,
        REG_FAR_DISTANCE  = 3'd5,
        REG_GAIN_OFFSET   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] near_gain;
        logic signed [31:0] far_gain;
        logic signed [31:0] near_slope;
        logic signed [31:0] far_slope;
        logic [30:0]        near_distance;
        logic [30:0]        far_distance;
        logic signed [31:0] gain_offset;
    } gain_cfg_t;

    typedef logic [ROM_W-1:0] rom_t [ROM_DEPTH];

    // restoring division, only evaluated while the table is built
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int bitpos = 63; bitpos >= 0; bitpos--)
        begin
            rem = {rem[63:0], num[bitpos]};
            if (rem >= {1'b0, den})
            begin
                rem         = rem - {1'b0, den};
                quo[bitpos] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(x) in Q24 by a truncated Taylor series
    function automatic logic [63:0] exp_q24(input logic [63:0] x);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = 64'd1 << EXP_BITS;
        term = sum;
        for (int n = 1; n <= EXP_TERMS; n++)
        begin
            term = div_u64((term * x) >> EXP_BITS, 64'(n));
            sum  = sum + term;
        end
        return sum;
    endfunction

    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] half;
        logic [63:0] pos;
        logic [63:0] mag;
        logic [63:0] s;
        half = 64'(ARG_LIMIT) << EXP_BITS;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            pos = div_u64((64'(2 * ARG_LIMIT) * 64'(i)) << EXP_BITS, 64'(ROM_DEPTH - 1));
            mag = (pos >= half) ? pos - half : half - pos;
            s   = div_u64(64'd1 << (EXP_BITS + FRAC_BITS),
                          (64'd1 << EXP_BITS) + exp_q24(mag));
            rom[i] = (pos >= half) ? ROM_W'(s) : ROM_W'((64'd1 << FRAC_BITS) - s);
        end
        return rom;
    endfunction

    localparam rom_t LOGISTIC_ROM = build_rom();

    // drop the fraction bits, rounding toward zero
    function automatic logic signed [PROD_W-1:0] trunc_rescale(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] bias;
        bias = {{(PROD_W - FRAC_BITS){1'b0}}, {FRAC_BITS{p[PROD_W-1]}}};
        return (p + bias) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        if (v < -66'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

// ===== rtl/core/sgvc_logistic.sv =====
// Five-stage logistic lookup: clamp, table position, table read, interpolation.
module sgvc_logistic (
    input  logic                               clk,
    input  logic                               en,
    input  logic                               negate,
    input  logic signed [sgvc_pkg::U_W-1:0]    u,
    output logic        [sgvc_pkg::ROM_W-1:0]  s
);

    localparam logic signed [sgvc_pkg::U_W-1:0] LIM_U = sgvc_pkg::U_W'(sgvc_pkg::ARG_LIM_Q);
    localparam logic signed [sgvc_pkg::ARG_W-1:0] LIM_A =
        sgvc_pkg::ARG_W'(sgvc_pkg::ARG_LIM_Q);

    logic signed [sgvc_pkg::ARG_W-1:0]  clamp_val;
    logic        [sgvc_pkg::ARG_W-1:0]  arg_next, arg_reg;
    logic        [sgvc_pkg::POS_W-1:0]  pos_full;
    logic        [sgvc_pkg::ROM_AW-1:0] idx_next, idx_reg;
    logic        [sgvc_pkg::FRAC_BITS-1:0] frac_next, frac_reg, frac2_reg;
    logic        [sgvc_pkg::ROM_W-1:0]  lo_val, hi_val;
    logic        [sgvc_pkg::ROM_W-1:0]  lo_reg, lo2_reg;
    logic signed [sgvc_pkg::ROM_W:0]    step_next, step_reg;
    logic signed [sgvc_pkg::ROM_W+sgvc_pkg::FRAC_BITS+1:0] prod_next, prod_reg;
    logic signed [sgvc_pkg::PROD_W-1:0] interp;
    logic        [sgvc_pkg::ROM_W-1:0]  s_next, s_reg;

    // clamp to the table span, mirror for the rising term, shift to zero base
    always_comb
    begin
        if (u > LIM_U)
            clamp_val = LIM_A;
        else if (u < -LIM_U)
            clamp_val = -LIM_A;
        else
            clamp_val = u[sgvc_pkg::ARG_W-1:0];
        if (negate)
            clamp_val = -clamp_val;
        arg_next = $unsigned(clamp_val) + $unsigned(LIM_A);
    end

    always_comb
    begin
        pos_full  = (sgvc_pkg::POS_W'(arg_reg) * sgvc_pkg::POS_W'(sgvc_pkg::ROM_DEPTH - 1))
                    >> sgvc_pkg::ARG_SHIFT;
        idx_next  = pos_full[sgvc_pkg::FRAC_BITS +: sgvc_pkg::ROM_AW];
        frac_next = pos_full[sgvc_pkg::FRAC_BITS-1:0];
    end

    always_comb
    begin
        lo_val = sgvc_pkg::LOGISTIC_ROM[idx_reg];
        hi_val = sgvc_pkg::LOGISTIC_ROM[idx_reg + 1'b1];
        if (idx_reg == sgvc_pkg::ROM_AW'(sgvc_pkg::ROM_DEPTH - 1))
            step_next = '0;
        else
            step_next = $signed({1'b0, hi_val}) - $signed({1'b0, lo_val});
    end

    always_comb
    begin
        prod_next = $signed({{(sgvc_pkg::FRAC_BITS+1){step_reg[sgvc_pkg::ROM_W]}}, step_reg})
                    * $signed({{(sgvc_pkg::ROM_W+2){1'b0}}, frac2_reg});
        interp = sgvc_pkg::trunc_rescale(sgvc_pkg::PROD_W'(prod_reg));
        s_next = sgvc_pkg::ROM_W'($signed({1'b0, lo2_reg}) + interp);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            arg_reg   <= arg_next;
            idx_reg   <= idx_next;
            frac_reg  <= frac_next;
            lo_reg    <= lo_val;
            step_reg  <= step_next;
            frac2_reg <= frac_reg;
            prod_reg  <= prod_next;
            lo2_reg   <= lo_reg;
            s_reg     <= s_next;
        end
    end

    assign s = s_reg;

endmodule

// ===== rtl/core/sgvc_gain_law.sv =====
// Pipelined gain law: two sigmoid terms over an error magnitude plus an offset.
module sgvc_gain_law (
    input  logic                      clk,
    input  logic                      en,
    input  sgvc_pkg::gain_cfg_t       cfg,
    input  logic [31:0]               e,
    output logic signed [31:0]        g
);

    logic signed [33:0]                  d1_next, d2_next, d1_reg, d2_reg;
    logic signed [sgvc_pkg::PROD_W-1:0]  p1_reg, p2_reg;
    logic signed [sgvc_pkg::U_W-1:0]     u1_reg, u2_reg;
    logic        [sgvc_pkg::ROM_W-1:0]   s1, s2;
    logic signed [sgvc_pkg::PROD_W-1:0]  m1_reg, m2_reg;
    logic signed [sgvc_pkg::PROD_W-1:0]  r1_reg, r2_reg;
    logic signed [31:0]                  g_reg;

    always_comb
    begin
        d1_next = $signed({2'b00, e}) - $signed({3'b000, cfg.near_distance});
        d2_next = $signed({2'b00, e}) - $signed({3'b000, cfg.far_distance});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg <= d1_next;
            d2_reg <= d2_next;
            p1_reg <= sgvc_pkg::PROD_W'(cfg.near_slope) * sgvc_pkg::PROD_W'(d1_reg);
            p2_reg <= sgvc_pkg::PROD_W'(cfg.far_slope) * sgvc_pkg::PROD_W'(d2_reg);
            u1_reg <= sgvc_pkg::U_W'(sgvc_pkg::trunc_rescale(p1_reg));
            u2_reg <= sgvc_pkg::U_W'(sgvc_pkg::trunc_rescale(p2_reg));
            m1_reg <= sgvc_pkg::PROD_W'(cfg.near_gain) * sgvc_pkg::PROD_W'($signed({1'b0, s1}));
            m2_reg <= sgvc_pkg::PROD_W'(cfg.far_gain) * sgvc_pkg::PROD_W'($signed({1'b0, s2}));
            r1_reg <= sgvc_pkg::trunc_rescale(m1_reg);
            r2_reg <= sgvc_pkg::trunc_rescale(m2_reg);
            g_reg  <= sgvc_pkg::sat32(r1_reg + r2_reg + sgvc_pkg::PROD_W'(cfg.gain_offset));
        end
    end

    sgvc_logistic u_near (
        .clk    (clk),
        .en     (en),
        .negate (1'b0),
        .u      (u1_reg),
        .s      (s1)
    );

    // rising term uses the mirrored argument
    sgvc_logistic u_far (
        .clk    (clk),
        .en     (en),
        .negate (1'b1),
        .u      (u2_reg),
        .s      (s2)
    );

    assign g = g_reg;

endmodule

// ===== rtl/core/sgvc_isqrt.sv =====
// Floor square root of a 64-bit value, one result bit per pipeline stage.
module sgvc_isqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] rad,
    output logic [31:0] root
);

    logic [63:0] v_reg [sgvc_pkg::SQRT_LAT-1];
    logic [63:0] r_reg [sgvc_pkg::SQRT_LAT];

    for (genvar k = 0; k < sgvc_pkg::SQRT_LAT; k++)
    begin : g_step
        logic [63:0] v_cur;
        logic [63:0] r_cur;
        logic [63:0] trial;
        logic [63:0] bit_val;

        if (k == 0)
        begin : g_first
            assign v_cur = rad;
            assign r_cur = '0;
        end
        else
        begin : g_rest
            assign v_cur = v_reg[k-1];
            assign r_cur = r_reg[k-1];
        end

        assign bit_val = 64'd1 << (62 - 2 * k);
        assign trial   = r_cur + bit_val;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (v_cur >= trial)
                    r_reg[k] <= (r_cur >> 1) + bit_val;
                else
                    r_reg[k] <= r_cur >> 1;
            end
        end

        if (k < sgvc_pkg::SQRT_LAT - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (v_cur >= trial)
                        v_reg[k] <= v_cur - trial;
                    else
                        v_reg[k] <= v_cur;
                end
            end
        end
    end

    assign root = r_reg[sgvc_pkg::SQRT_LAT-1][31:0];

endmodule

// ===== rtl/core/sigmoid_gain_velocity_controller.sv =====
// Top level: config registers, per-axis error, velocity, distance and overall gain.
// From input accept to result valid an item passes the error, square and radicand registers,
// the 32-stage root, the 11-stage gain-law pipeline on the distance and the output register.
// Throughput: one item per cycle; an output stall freezes every stage at once.
// Reset: valid bits cleared, all config registers return to 1.0 (Q16.16).
module sigmoid_gain_velocity_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] measured_x,
    input  logic signed [31:0] measured_y,
    input  logic signed [31:0] measured_z,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] velocity_x,
    output logic signed [31:0] velocity_y,
    output logic signed [31:0] velocity_z,
    output logic        [31:0] distance,
    output logic signed [31:0] overall_gain,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int GL    = sgvc_pkg::GAIN_LAT;
    localparam int SL    = sgvc_pkg::SQRT_LAT;
    localparam int LAT   = 3 + SL + GL + 1;

    sgvc_pkg::gain_cfg_t cfg;
    logic [31:0] near_gain_reg, far_gain_reg, near_slope_reg, far_slope_reg;
    logic [30:0] near_distance_reg, far_distance_reg;
    logic [31:0] gain_offset_reg;

    logic en;
    logic [LAT-1:0] valid_reg;

    logic signed [31:0] meas [3];
    logic signed [31:0] targ [3];
    logic signed [32:0] err_next [3];
    logic        [31:0] mag_next [3];
    logic signed [32:0] err_reg  [3];
    logic        [31:0] mag_reg  [3];
    logic signed [31:0] g_axis   [3];
    logic signed [32:0] err_dly_reg [3][GL];
    logic signed [sgvc_pkg::PROD_W-1:0] vprod_reg [3];
    logic signed [31:0] vel_reg  [3];
    logic signed [31:0] vel_dly_reg [3][SL];
    logic        [63:0] sq_reg   [3];
    logic        [65:0] sum_sq;
    logic        [63:0] rad_reg;
    logic        [31:0] root;
    logic signed [31:0] g_dist;
    logic        [31:0] dist_dly_reg [GL];
    logic signed [31:0] vel_out_reg [3];
    logic        [31:0] distance_reg;
    logic signed [31:0] overall_gain_reg;

    // whole pipeline advances unless a finished result is held
    assign en       = !(valid_reg[LAT-1] && out_stall);
    assign in_stall = !en;
    assign out_valid = valid_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_gain_reg     <= sgvc_pkg::CFG_RESET;
            far_gain_reg      <= sgvc_pkg::CFG_RESET;
            near_slope_reg    <= sgvc_pkg::CFG_RESET;
            far_slope_reg     <= sgvc_pkg::CFG_RESET;
            near_distance_reg <= sgvc_pkg::CFG_RESET[30:0];
            far_distance_reg  <= sgvc_pkg::CFG_RESET[30:0];
            gain_offset_reg   <= sgvc_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sgvc_pkg::REG_NEAR_GAIN:     near_gain_reg     <= cfg_data;
                sgvc_pkg::REG_FAR_GAIN:      far_gain_reg      <= cfg_data;
                sgvc_pkg::REG_NEAR_SLOPE:    near_slope_reg    <= cfg_data;
                sgvc_pkg::REG_FAR_SLOPE:     far_slope_reg     <= cfg_data;
                sgvc_pkg::REG_NEAR_DISTANCE: near_distance_reg <= cfg_data[30:0];
                sgvc_pkg::REG_FAR_DISTANCE:  far_distance_reg  <= cfg_data[30:0];
                sgvc_pkg::REG_GAIN_OFFSET:   gain_offset_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.near_gain     = $signed(near_gain_reg);
        cfg.far_gain      = $signed(far_gain_reg);
        cfg.near_slope    = $signed(near_slope_reg);
        cfg.far_slope     = $signed(far_slope_reg);
        cfg.near_distance = near_distance_reg;
        cfg.far_distance  = far_distance_reg;
        cfg.gain_offset   = $signed(gain_offset_reg);
    end

    always_comb
    begin
        meas[0] = measured_x;
        meas[1] = measured_y;
        meas[2] = measured_z;
        targ[0] = target_x;
        targ[1] = target_y;
        targ[2] = target_z;
        for (int k = 0; k < 3; k++)
        begin
            err_next[k] = 33'(targ[k]) - 33'(meas[k]);
            mag_next[k] = err_next[k][32] ? 32'(-err_next[k]) : err_next[k][31:0];
        end
        sum_sq = 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_axis_law
        sgvc_gain_law u_gain (
            .clk (clk),
            .en  (en),
            .cfg (cfg),
            .e   (mag_reg[k]),
            .g   (g_axis[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                err_reg[k]        <= err_next[k];
                mag_reg[k]        <= mag_next[k];
                err_dly_reg[k][0] <= err_reg[k];
                for (int j = 1; j < GL; j++)
                    err_dly_reg[k][j] <= err_dly_reg[k][j-1];
                vprod_reg[k] <= sgvc_pkg::PROD_W'(g_axis[k])
                                * sgvc_pkg::PROD_W'(err_dly_reg[k][GL-1]);
                vel_reg[k]   <= sgvc_pkg::sat32(sgvc_pkg::trunc_rescale(vprod_reg[k]));
                vel_dly_reg[k][0] <= vel_reg[k];
                for (int j = 1; j < SL; j++)
                    vel_dly_reg[k][j] <= vel_dly_reg[k][j-1];
                sq_reg[k]      <= 64'(mag_reg[k]) * 64'(mag_reg[k]);
                vel_out_reg[k] <= vel_dly_reg[k][SL-1];
            end
            // a sum past 64 bits saturates; the root of all ones is all ones
            rad_reg <= (sum_sq[65:64] != 2'b00) ? '1 : sum_sq[63:0];
            dist_dly_reg[0] <= root;
            for (int j = 1; j < GL; j++)
                dist_dly_reg[j] <= dist_dly_reg[j-1];
            distance_reg     <= dist_dly_reg[GL-1];
            overall_gain_reg <= g_dist;
        end
    end

    sgvc_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .rad  (rad_reg),
        .root (root)
    );

    sgvc_gain_law u_dist_gain (
        .clk (clk),
        .en  (en),
        .cfg (cfg),
        .e   (root),
        .g   (g_dist)
    );

    assign velocity_x   = vel_out_reg[0];
    assign velocity_y   = vel_out_reg[1];
    assign velocity_z   = vel_out_reg[2];
    assign distance     = distance_reg;
    assign overall_gain = overall_gain_reg;

endmodule

// ===== rtl/core/sgvc_checker.sv =====
// Port-level checks for the controller, bound to the top level.
module sgvc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] velocity_x,
    input logic signed [31:0] velocity_y,
    input logic signed [31:0] velocity_z,
    input logic        [31:0] distance,
    input logic signed [31:0] overall_gain
);

    // input side only backs up behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // zero distance means every axis error was zero
    a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && distance == 32'd0) |->
            (velocity_x == 32'sd0 && velocity_y == 32'sd0 && velocity_z == 32'sd0))
        else $error("nonzero velocity at zero distance");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("held result dropped");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            ($stable(velocity_x) && $stable(distance) && $stable(overall_gain)))
        else $error("held result changed");

endmodule

bind sigmoid_gain_velocity_controller sgvc_checker u_sgvc_checker (.*);

// ===== test/sigmoid_gain_velocity_checker.sv =====
// Result checker for the sigmoid-gain velocity controller: predicts each item and compares.
module sigmoid_gain_velocity_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] measured_x,
    input  logic signed [31:0] measured_y,
    input  logic signed [31:0] measured_z,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] velocity_x,
    input  logic signed [31:0] velocity_y,
    input  logic signed [31:0] velocity_z,
    input  logic        [31:0] distance,
    input  logic signed [31:0] overall_gain,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 failures,
    output int                 pending
);
    import sgvc_pkg::*;

    typedef struct {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic        [31:0] span;
        logic signed [31:0] gain;
    } command_t;

    command_t           command_queue[$];
    logic        [31:0] sigmoid_rom [ROM_DEPTH];
    logic signed [31:0] k_near_gain, k_far_gain, k_near_slope, k_far_slope, k_offset;
    logic        [30:0] k_near_dist, k_far_dist;

    function automatic logic [63:0] exp_series(logic [63:0] x);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = 64'd1 << 24;
        term = sum;
        for (int n = 1; n <= 48; n++)
        begin
            term = ((term * x) >> 24) / 64'(n);
            sum  = sum + term;
        end
        return sum;
    endfunction

    initial
    begin
        logic [63:0] half, pos, mag, s;
        half = 64'd8 << 24;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            pos = ((64'd16 * 64'(i)) << 24) / 64'(ROM_DEPTH - 1);
            mag = (pos >= half) ? pos - half : half - pos;
            s   = (64'd1 << 40) / ((64'd1 << 24) + exp_series(mag));
            sigmoid_rom[i] = (pos >= half) ? 32'(s) : 32'((64'd1 << 16) - s);
        end
    end

    // product over 2^16, truncated toward zero
    function automatic longint scale_mul(longint a, longint b);
        logic [63:0] ua, ub, q;
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        q  = (ua * ub) >> 16;
        return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint sigmoid_lookup(longint u);
        longint lim, p, idx, lo, step;
        lim = 64'sd8 << 16;
        if (u > lim)
            u = lim;
        if (u < -lim)
            u = -lim;
        p   = ((u + lim) * (ROM_DEPTH - 1)) / 16;
        idx = p >>> 16;
        if (idx >= ROM_DEPTH - 1)
            return longint'(sigmoid_rom[ROM_DEPTH - 1]);
        lo   = longint'(sigmoid_rom[idx]);
        step = longint'(sigmoid_rom[idx + 1]) - lo;
        return lo + scale_mul(step, p & 64'hffff);
    endfunction

    function automatic longint gain_law(logic [63:0] e);
        longint ei, u1, u2, g;
        ei = longint'(e);
        u1 = scale_mul(longint'(k_near_slope), ei - longint'(k_near_dist));
        u2 = scale_mul(longint'(k_far_slope), ei - longint'(k_far_dist));
        g  = scale_mul(longint'(k_near_gain), sigmoid_lookup(u1))
           + scale_mul(longint'(k_far_gain), sigmoid_lookup(-u2))
           + longint'(k_offset);
        return clip32(g);
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] root, bits;
        root = 0;
        bits = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (v >= root + bits)
            begin
                v    = v - (root + bits);
                root = (root >> 1) + bits;
            end
            else
                root = root >> 1;
            bits = bits >> 2;
        end
        return root;
    endfunction

    function automatic command_t predict_command(logic signed [31:0] mp [3],
                                                 logic signed [31:0] tp [3]);
        command_t    c;
        longint      err, g;
        logic [63:0] mag, sq, sumsq, span;
        logic        over;
        logic signed [31:0] vel [3];
        sumsq = 0;
        over  = 0;
        for (int k = 0; k < 3; k++)
        begin
            err    = longint'(tp[k]) - longint'(mp[k]);
            mag    = (err < 0) ? 64'(-err) : 64'(err);
            g      = gain_law(mag);
            vel[k] = 32'(clip32(scale_mul(g, err)));
            sq     = mag * mag;
            if (sumsq > 64'hffffffffffffffff - sq)
                over = 1;
            else
                sumsq = sumsq + sq;
        end
        span = over ? 64'hffffffff : floor_sqrt(sumsq);
        if (span > 64'hffffffff)
            span = 64'hffffffff;
        c.vel_x = vel[0];
        c.vel_y = vel[1];
        c.vel_z = vel[2];
        c.span  = span[31:0];
        c.gain  = 32'(gain_law(span));
        return c;
    endfunction

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            failures++;
            if (failures <= 10)
                $display("mismatch %s: expected %h actual %h", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_near_gain  <= CFG_RESET;
            k_far_gain   <= CFG_RESET;
            k_near_slope <= CFG_RESET;
            k_far_slope  <= CFG_RESET;
            k_near_dist  <= CFG_RESET[30:0];
            k_far_dist   <= CFG_RESET[30:0];
            k_offset     <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NEAR_GAIN:     k_near_gain  <= cfg_data;
                REG_FAR_GAIN:      k_far_gain   <= cfg_data;
                REG_NEAR_SLOPE:    k_near_slope <= cfg_data;
                REG_FAR_SLOPE:     k_far_slope  <= cfg_data;
                REG_NEAR_DISTANCE: k_near_dist  <= cfg_data[30:0];
                REG_FAR_DISTANCE:  k_far_dist   <= cfg_data[30:0];
                REG_GAIN_OFFSET:   k_offset     <= cfg_data;
                default: ;
            endcase
        end
    end

    initial
    begin
        failures = 0;
        pending  = 0;
    end

    always @(posedge clk)
    begin
        command_t want;
        logic signed [31:0] mp [3];
        logic signed [31:0] tp [3];
        if (rst_n && in_valid && !in_stall)
        begin
            mp = '{measured_x, measured_y, measured_z};
            tp = '{target_x, target_y, target_z};
            command_queue.insert(command_queue.size(), predict_command(mp, tp));
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (command_queue.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result item: distance %h", distance);
            end
            else
            begin
                want = command_queue.pop_front();
                report_field("velocity_x", want.vel_x, velocity_x);
                report_field("velocity_y", want.vel_y, velocity_y);
                report_field("velocity_z", want.vel_z, velocity_z);
                report_field("distance", want.span, distance);
                report_field("overall_gain", want.gain, overall_gain);
            end
        end
        pending = command_queue.size();
    end

endmodule

// ===== test/sigmoid_gain_velocity_controller_test.sv =====
// Testbench top for the sigmoid-gain velocity controller: stimulus, config phases, verdict.
module sigmoid_gain_velocity_controller_test;
    import sgvc_pkg::*;

    localparam logic [2:0] UNUSED_INDEX = 3'd7;

    logic               clk = 0;
    logic               rst_n;
    logic               in_valid, in_stall;
    logic signed [31:0] measured_x, measured_y, measured_z;
    logic signed [31:0] target_x, target_y, target_z;
    logic               out_valid, out_stall;
    logic signed [31:0] velocity_x, velocity_y, velocity_z;
    logic        [31:0] distance;
    logic signed [31:0] overall_gain;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    int                 failures, pending;
    logic               quiet = 0;

    sigmoid_gain_velocity_controller dut (.*);

    sigmoid_gain_velocity_checker checker_i (.*);

    always #5 clk = ~clk;

    initial
    begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver stall bursts
    initial
    begin
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                out_stall <= 0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task automatic send_item(input logic [31:0] mx, my, mz, tx, ty, tz);
        measured_x <= mx;
        measured_y <= my;
        measured_z <= mz;
        target_x   <= tx;
        target_y   <= ty;
        target_z   <= tz;
        in_valid   <= 1;
        do
            @(posedge clk);
        while (in_stall);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // mode 0 moderate, 1 all max, 2 all min, 3 zero, 4 full random
    task automatic load_gains(input int mode);
        logic [31:0] v [7];
        for (int i = 0; i < 7; i++)
        begin
            case (mode)
                1: v[i] = (i == 4 || i == 5) ? 32'h7fffffff : 32'h7fffffff;
                2: v[i] = (i == 4 || i == 5) ? 32'h0 : 32'h80000000;
                3: v[i] = 32'h0;
                4: v[i] = $urandom;
                default:
                    if (i < 2 || i == 6)
                        v[i] = $urandom_range(0, 1 << 19) - (1 << 18);
                    else if (i < 4)
                        v[i] = $urandom_range(0, 8 << 16);
                    else
                        v[i] = $urandom_range(0, 4 << 16);
            endcase
        end
        write_reg(REG_NEAR_GAIN, v[0]);
        write_reg(REG_FAR_GAIN, v[1]);
        write_reg(REG_NEAR_SLOPE, v[2]);
        write_reg(REG_FAR_SLOPE, v[3]);
        write_reg(REG_NEAR_DISTANCE, v[4]);
        write_reg(REG_FAR_DISTANCE, v[5]);
        write_reg(REG_GAIN_OFFSET, v[6]);
    endtask

    function automatic logic [31:0] near_offset();
        return $urandom_range(0, 1 << 20) - (1 << 19);
    endfunction

    task automatic random_item();
        logic [31:0] m [3];
        logic [31:0] t [3];
        int          shape;
        shape = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++)
        begin
            m[k] = (shape < 3) ? $urandom : near_offset();
            if (shape < 5)
                t[k] = $urandom;
            else if (shape < 8)
                t[k] = m[k] + near_offset();
            else
                t[k] = m[k] + ($urandom_range(0, 1 << 17) - (1 << 16));
        end
        send_item(m[0], m[1], m[2], t[0], t[1], t[2]);
    endtask

    initial
    begin
        int modes [6];
        modes = '{0, 1, 2, 3, 4, 0};
        rst_n      <= 0;
        in_valid   <= 0;
        measured_x <= 0;
        measured_y <= 0;
        measured_z <= 0;
        target_x   <= 0;
        target_y   <= 0;
        target_z   <= 0;
        cfg_we     <= 0;
        cfg_index  <= 0;
        cfg_data   <= 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed items at reset gains
        send_item(0, 0, 0, 0, 0, 0);
        send_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h80000000, 32'h80000000, 32'h80000000);
        send_item(32'h80000000, 32'h80000000, 32'h80000000,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_item(32'h80000000, 0, 0, 32'h7fffffff, 0, 0);
        send_item(0, 32'h7fffffff, 0, 0, 32'h80000000, 0);
        send_item(0, 0, 32'h80000000, 0, 0, 32'h7fffffff);
        send_item(0, 0, 0, 32'h00010000, 0, 0);
        send_item(0, 0, 0, 0, 32'hffff0000, 0);
        send_item(0, 0, 0, 0, 0, 32'h00008000);
        send_item(0, 0, 0, 32'h00100000, 32'hfff00000, 32'h00080000);
        send_item(0, 0, 0, 32'h00000001, 32'hffffffff, 32'h00000001);
        send_item(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0);
        send_item(32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f,
                  32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f);
        send_item(32'h40000000, 32'hc0000000, 32'h40000000,
                  32'hc0000000, 32'h40000000, 32'hc0000000);
        send_item(0, 0, 0, 32'h00090000, 0, 0);
        wait_drained();
        write_reg(UNUSED_INDEX, 32'hdeadbeef);
        load_gains(1);
        send_item(0, 0, 0, 32'h00020000, 32'h80000000, 32'h00000100);
        send_item(32'h80000000, 0, 0, 32'h7fffffff, 32'h00010000, 0);
        wait_drained();
        load_gains(2);
        send_item(0, 0, 0, 32'h00020000, 32'h7fffffff, 32'h00000100);
        send_item(32'h80000000, 0, 0, 32'h7fffffff, 32'h00010000, 0);
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            load_gains(modes[ph]);
            if (ph == 5)
                quiet <= 1;
            repeat (115) random_item();
            wait_drained();
        end

        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
